// ----- hdl/amb_pkg.sv -----
// Package for the 2D affine matrix builder: widths, mode codes, payload types,
// and the sine/cosine split tables. No dependencies.
package amb_pkg;

  localparam int unsigned AngleBits = 16;
  localparam int unsigned QuadBits  = AngleBits - 2;
  localparam int unsigned LoBits    = QuadBits / 2;
  localparam int unsigned HiBits    = QuadBits - LoBits;
  localparam int unsigned TabN      = 1 << HiBits;
  localparam int unsigned TabFrac   = 30;
  localparam int unsigned TabW      = TabFrac + 1;
  localparam int unsigned EntW      = 60;

  // radians per angle LSB
  localparam real TurnStep = 2.0 * 3.14159265358979323846 / real'(1 << AngleBits);

  typedef enum logic [3:0] {
    MODE_S     = 4'd0,
    MODE_T     = 4'd1,
    MODE_R     = 4'd2,
    MODE_ST    = 4'd3,
    MODE_TS    = 4'd4,
    MODE_SR    = 4'd5,
    MODE_RS    = 4'd6,
    MODE_TR    = 4'd7,
    MODE_RT    = 4'd8,
    MODE_STR   = 4'd9,
    MODE_SRT   = 4'd10,
    MODE_TSR   = 4'd11,
    MODE_TRS   = 4'd12,
    MODE_RST   = 4'd13,
    MODE_RTS   = 4'd14,
    MODE_IDENT = 4'd15
  } mode_e;

  typedef struct packed {
    logic [3:0]           mode;
    logic                 left_handed;
    logic [15:0]          angle;
    logic signed [15:0]   scale_x;
    logic signed [15:0]   scale_y;
    logic signed [23:0]   trans_x;
    logic signed [23:0]   trans_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
  } out_item_t;

  typedef logic [TabW-1:0] tab_t [TabN];

  // sin/cos of (idx << shift) / 2^AngleBits turns, unsigned Q1.30
  function automatic tab_t gen_tab(input bit is_cos, input int unsigned shift);
    tab_t t;
    real  ang;
    real  v;
    for (int i = 0; i < TabN; i++) begin
      ang = real'(i * (1 << shift)) * TurnStep;
      v = is_cos ? $cos(ang) : $sin(ang);
      t[i] = TabW'($rtoi(v * real'(1 << TabFrac) + 0.5));
    end
    return t;
  endfunction

  localparam tab_t SinHi = gen_tab(1'b0, LoBits);
  localparam tab_t CosHi = gen_tab(1'b1, LoBits);
  localparam tab_t SinLo = gen_tab(1'b0, 0);
  localparam tab_t CosLo = gen_tab(1'b1, 0);

endpackage

// ----- hdl/amb_if.sv -----
// Valid/ready channel interfaces for input items and result items.
// Depends on amb_pkg.
interface amb_in_if;
  logic               valid;
  logic               ready;
  amb_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface amb_out_if;
  logic                valid;
  logic                ready;
  amb_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/amb_sincos.sv -----
// Three-stage sine/cosine: split table lookup, four products, sum/round/quadrant.
// Depends on amb_pkg.
module amb_sincos (
  input  logic                          clk_i,
  input  logic [2:0]                    en_i,
  input  logic [amb_pkg::AngleBits-1:0] angle_i,
  input  logic                          left_handed_i,
  output logic signed [15:0]            sin_o,
  output logic signed [15:0]            cos_o
);
  localparam int unsigned AB = amb_pkg::AngleBits;
  localparam int unsigned QB = amb_pkg::QuadBits;
  localparam int unsigned LB = amb_pkg::LoBits;
  localparam int unsigned HB = amb_pkg::HiBits;
  localparam int unsigned TW = amb_pkg::TabW;
  localparam int unsigned PW = 2 * TW;
  localparam int unsigned RS = 2 * amb_pkg::TabFrac - 15;

  logic [AB-1:0]  ang;
  logic [QB-1:0]  rem;
  logic [HB-1:0]  hi_idx, lo_idx;

  logic [1:0]     q1_q, q2_q;
  logic [TW-1:0]  sh_q, ch_q, sl_q, cl_q;
  logic [PW-1:0]  shcl_q, chsl_q, chcl_q, shsl_q;
  logic [PW:0]    s_sum, c_sum, s_rnd, c_rnd;
  logic [15:0]    s_u, c_u;
  logic signed [15:0] s_d, c_d, sin_q, cos_q;

  always_comb begin
    ang    = left_handed_i ? AB'(~angle_i + 1'b1) : angle_i;
    rem    = ang[QB-1:0];
    hi_idx = rem[QB-1:LB];
    lo_idx = HB'(rem[LB-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      q1_q <= ang[AB-1:AB-2];
      sh_q <= amb_pkg::SinHi[hi_idx];
      ch_q <= amb_pkg::CosHi[hi_idx];
      sl_q <= amb_pkg::SinLo[lo_idx];
      cl_q <= amb_pkg::CosLo[lo_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      q2_q   <= q1_q;
      shcl_q <= sh_q * cl_q;
      chsl_q <= ch_q * sl_q;
      chcl_q <= ch_q * cl_q;
      shsl_q <= sh_q * sl_q;
    end
  end

  // angle sum identities, then round to Q1.15 and clamp
  always_comb begin
    s_sum = (PW+1)'(shcl_q) + (PW+1)'(chsl_q);
    c_sum = (PW+1)'(chcl_q) - (PW+1)'(shsl_q);
    s_rnd = (s_sum + ((PW+1)'(1) << (RS - 1))) >> RS;
    c_rnd = (c_sum + ((PW+1)'(1) << (RS - 1))) >> RS;
    s_u   = (s_rnd > (PW+1)'(32767)) ? 16'd32767 : s_rnd[15:0];
    c_u   = (c_rnd > (PW+1)'(32767)) ? 16'd32767 : c_rnd[15:0];
    unique case (q2_q)
      2'd0: begin s_d = s_u;         c_d = c_u;         end
      2'd1: begin s_d = c_u;         c_d = -$signed(s_u); end
      2'd2: begin s_d = -$signed(s_u); c_d = -$signed(c_u); end
      default: begin s_d = -$signed(c_u); c_d = s_u;    end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sin_q <= s_d;
      cos_q <= c_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;
endmodule

// ----- hdl/affine_2d_matrix_builder_core.sv -----
// Top level of the 2D affine matrix builder: seven-stage pipeline from input
// item to the six Q16.16 matrix entries. Depends on amb_pkg, amb_if, amb_sincos.
//
//  channel  dir  handshake     payload
//  in_i     in   valid/ready   mode, left_handed, angle, scale_x/y, trans_x/y
//  res_o    out  valid/ready   m00 m01 m10 m11 m20 m21
//
// One transfer per cycle in steady state when the output is not stalled. The
// stages are the sine/cosine stages (3), the multiply chain sx*tx*c / sx*rx (3)
// and the final round/saturate stage.
// Reset clears the stage valid bits only; data registers are not reset.
// Each stage moves when its successor is empty or moving, so a stalled output
// backs up stage by stage and bubbles collapse; nothing is dropped or repeated.
module affine_2d_matrix_builder_core (
  input  logic clk_i,
  input  logic rst_ni,
  amb_in_if.sink    in_i,
  amb_out_if.source res_o
);
  localparam int unsigned EW = amb_pkg::EntW;
  localparam int unsigned NS = 7;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [23:0] tx;
    logic signed [23:0] ty;
  } fld_t;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;
  fld_t          fld_q [6];
  fld_t          fld_in;

  logic signed [15:0] sin_w, cos_w;

  // stage 4 products
  logic signed [31:0] sxc_q, sxs_q, syc_q, sys_q;
  logic signed [39:0] txc_q, tys_q, txs_q, tyc_q, sxtx_q, syty_q;
  logic signed [15:0] c4_q, s4_q;
  // stage 5
  logic signed [31:0] sxc5_q, sxs5_q, syc5_q, sys5_q;
  logic signed [40:0] rx_q, ry_q;
  logic signed [55:0] sxtxc_q, sxtxs_q, sytyc_q, sytys_q;
  logic signed [39:0] sxtx5_q, syty5_q;
  logic signed [15:0] c5_q, s5_q;
  // stage 6
  logic signed [31:0] sxc6_q, sxs6_q, syc6_q, sys6_q;
  logic signed [40:0] rx6_q, ry6_q;
  logic signed [56:0] srx_q, sry_q, e11x_q, e11y_q;
  logic signed [39:0] sxtx6_q, syty6_q;
  logic signed [15:0] c6_q, s6_q;

  logic signed [EW-1:0] e [6];
  logic signed [31:0]   m [6];
  amb_pkg::out_item_t   out_q;

  // stage enables: a stage loads when empty or when its successor loads
  always_comb begin
    en[NS-1] = !v_q[NS-1] || res_o.ready;
    for (int k = NS - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign fld_in = '{mode: in_i.data.mode, sx: in_i.data.scale_x, sy: in_i.data.scale_y,
                    tx: in_i.data.trans_x, ty: in_i.data.trans_y};

  // fields ride alongside the pipeline
  always_ff @(posedge clk_i) begin
    if (en[0]) fld_q[0] <= fld_in;
    for (int k = 1; k < 6; k++) begin
      if (en[k]) fld_q[k] <= fld_q[k-1];
    end
  end

  // stages 1..3
  amb_sincos u_sincos (
    .clk_i         (clk_i),
    .en_i          (en[2:0]),
    .angle_i       (in_i.data.angle[amb_pkg::AngleBits-1:0]),
    .left_handed_i (in_i.data.left_handed),
    .sin_o         (sin_w),
    .cos_o         (cos_w)
  );

  // stage 4: first-level products
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sxc_q  <= fld_q[2].sx * cos_w;
      sxs_q  <= fld_q[2].sx * sin_w;
      syc_q  <= fld_q[2].sy * cos_w;
      sys_q  <= fld_q[2].sy * sin_w;
      txc_q  <= fld_q[2].tx * cos_w;
      tys_q  <= fld_q[2].ty * sin_w;
      txs_q  <= fld_q[2].tx * sin_w;
      tyc_q  <= fld_q[2].ty * cos_w;
      sxtx_q <= fld_q[2].sx * fld_q[2].tx;
      syty_q <= fld_q[2].sy * fld_q[2].ty;
      c4_q   <= cos_w;
      s4_q   <= sin_w;
    end
  end

  // stage 5: rotated translation, scaled translation times c/s
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      rx_q    <= 41'(txc_q) - 41'(tys_q);
      ry_q    <= 41'(txs_q) + 41'(tyc_q);
      sxtxc_q <= sxtx_q * c4_q;
      sxtxs_q <= sxtx_q * s4_q;
      sytyc_q <= syty_q * c4_q;
      sytys_q <= syty_q * s4_q;
      sxc5_q  <= sxc_q;
      sxs5_q  <= sxs_q;
      syc5_q  <= syc_q;
      sys5_q  <= sys_q;
      sxtx5_q <= sxtx_q;
      syty5_q <= syty_q;
      c5_q    <= c4_q;
      s5_q    <= s4_q;
    end
  end

  // stage 6: scale after rotate-translate, combined translation rows
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      srx_q   <= fld_q[4].sx * rx_q;
      sry_q   <= fld_q[4].sy * ry_q;
      e11x_q  <= 57'(sxtxc_q) - 57'(sytys_q);
      e11y_q  <= 57'(sxtxs_q) + 57'(sytyc_q);
      rx6_q   <= rx_q;
      ry6_q   <= ry_q;
      sxc6_q  <= sxc5_q;
      sxs6_q  <= sxs5_q;
      syc6_q  <= syc5_q;
      sys6_q  <= sys5_q;
      sxtx6_q <= sxtx5_q;
      syty6_q <= syty5_q;
      c6_q    <= c5_q;
      s6_q    <= s5_q;
    end
  end

  // stage 7: pick entries by mode, all at 31 fractional bits
  always_comb begin
    fld_t f;
    logic signed [EW-1:0] one, sx23, sy23, tx23, ty23, c16, s16;
    logic signed [EW-1:0] sxc8, sxs8, syc8, sys8, rx8, ry8, sxtx15, syty15;
    logic signed [EW-1:0] rnd;
    f      = fld_q[5];
    one    = EW'(1) <<< 31;
    sx23   = EW'(f.sx) <<< 23;
    sy23   = EW'(f.sy) <<< 23;
    tx23   = EW'(f.tx) <<< 23;
    ty23   = EW'(f.ty) <<< 23;
    c16    = EW'(c6_q) <<< 16;
    s16    = EW'(s6_q) <<< 16;
    sxc8   = EW'(sxc6_q) <<< 8;
    sxs8   = EW'(sxs6_q) <<< 8;
    syc8   = EW'(syc6_q) <<< 8;
    sys8   = EW'(sys6_q) <<< 8;
    rx8    = EW'(rx6_q) <<< 8;
    ry8    = EW'(ry6_q) <<< 8;
    sxtx15 = EW'(sxtx6_q) <<< 15;
    syty15 = EW'(syty6_q) <<< 15;
    for (int j = 0; j < 6; j++) e[j] = '0;
    unique case (amb_pkg::mode_e'(f.mode))
      amb_pkg::MODE_S: begin e[0] = sx23; e[3] = sy23; end
      amb_pkg::MODE_T: begin
        e[0] = one; e[3] = one; e[4] = tx23; e[5] = ty23;
      end
      amb_pkg::MODE_R: begin e[0] = c16; e[1] = s16; e[2] = -s16; e[3] = c16; end
      amb_pkg::MODE_TR: begin
        e[0] = c16; e[1] = s16; e[2] = -s16; e[3] = c16; e[4] = rx8; e[5] = ry8;
      end
      amb_pkg::MODE_RT: begin
        e[0] = c16; e[1] = s16; e[2] = -s16; e[3] = c16; e[4] = tx23; e[5] = ty23;
      end
      amb_pkg::MODE_ST: begin
        e[0] = sx23; e[3] = sy23; e[4] = tx23; e[5] = ty23;
      end
      amb_pkg::MODE_TS: begin
        e[0] = sx23; e[3] = sy23; e[4] = sxtx15; e[5] = syty15;
      end
      amb_pkg::MODE_SR: begin
        e[0] = sxc8; e[1] = sxs8; e[2] = -sys8; e[3] = syc8;
      end
      amb_pkg::MODE_STR: begin
        e[0] = sxc8; e[1] = sxs8; e[2] = -sys8; e[3] = syc8; e[4] = rx8; e[5] = ry8;
      end
      amb_pkg::MODE_SRT: begin
        e[0] = sxc8; e[1] = sxs8; e[2] = -sys8; e[3] = syc8; e[4] = tx23; e[5] = ty23;
      end
      amb_pkg::MODE_TSR, amb_pkg::MODE_RST: begin
        e[0] = sxc8; e[1] = sxs8; e[2] = -sys8; e[3] = syc8;
        e[4] = EW'(e11x_q); e[5] = EW'(e11y_q);
      end
      amb_pkg::MODE_RS: begin
        e[0] = sxc8; e[1] = sys8; e[2] = -sxs8; e[3] = syc8;
      end
      amb_pkg::MODE_TRS: begin
        e[0] = sxc8; e[1] = sys8; e[2] = -sxs8; e[3] = syc8;
        e[4] = EW'(srx_q); e[5] = EW'(sry_q);
      end
      amb_pkg::MODE_RTS: begin
        e[0] = sxc8; e[1] = sys8; e[2] = -sxs8; e[3] = syc8;
        e[4] = sxtx15; e[5] = syty15;
      end
      default: begin e[0] = one; e[3] = one; end
    endcase
    // round half up to Q16.16, saturate to 32 bits
    for (int j = 0; j < 6; j++) begin
      rnd = (e[j] + (EW'(1) <<< 14)) >>> 15;
      if (rnd > EW'(32'sh7fff_ffff))       m[j] = 32'sh7fff_ffff;
      else if (rnd < -(EW'(1) <<< 31))     m[j] = 32'sh8000_0000;
      else                                 m[j] = rnd[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      out_q.m00 <= m[0];
      out_q.m01 <= m[1];
      out_q.m10 <= m[2];
      out_q.m11 <= m[3];
      out_q.m20 <= m[4];
      out_q.m21 <= m[5];
    end
  end

  assign res_o.valid = v_q[NS-1];
  assign res_o.data  = out_q;
endmodule

// ----- hdl/amb_checker.sv -----
// Port-level assertions for the affine matrix builder, bound to the top level.
// Depends on amb_pkg and affine_2d_matrix_builder_core.
module amb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input amb_pkg::out_item_t out_data_i
);
  // a result offered and not taken stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // and its payload does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result payload changed while stalled");

  // a free output means the whole pipeline can move
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input blocked while output is free");

  // nothing is offered during reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result offered during reset");
endmodule

bind affine_2d_matrix_builder_core amb_checker u_amb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_data_i  (res_o.data)
);
